/* sv/pse_pkg.sv */
package pse_pkg;

    // Default bound on the sieve range; the top level hands it down.
    localparam int PSE_MAX_LIMIT = 4096;

    localparam logic CMD_SWEEP = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] index;
    } t_req;

    typedef struct packed {
        logic [12:0] cost;
        logic [12:0] prime_count;
        logic [12:0] prime_value;
        logic        out_of_range;
    } t_rsp;

    // Datapath operations selected by the control word of a step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_FILL,
        OP_SINIT,
        OP_SQTEST,
        OP_KLOAD,
        OP_STRIKE,
        OP_DRAIN_S,
        OP_ADVANCE,
        OP_CINIT,
        OP_COLLECT,
        OP_DRAIN_C,
        OP_SWEEP_OUT,
        OP_RD_ISSUE,
        OP_READ_OUT
    } t_op;

    // Jump conditions. A true condition jumps to the target, otherwise the
    // program falls through to the next step.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_IS_READ,
        C_K_LT_TOP,
        C_SQ_GT_TOP,
        C_NOT_MARK,
        C_KJ_LE_TOP,
        C_K_GT_TOP,
        C_OUT_BUSY
    } t_cond;

    typedef logic [4:0] t_step;

    localparam t_step P_IDLE    = 5'd0;
    localparam t_step P_DISP    = 5'd1;
    localparam t_step P_CLR0    = 5'd2;
    localparam t_step P_FILL    = 5'd3;
    localparam t_step P_SINIT   = 5'd4;
    localparam t_step P_SCHK    = 5'd5;
    localparam t_step P_SJT     = 5'd6;
    localparam t_step P_STRIKE  = 5'd7;
    localparam t_step P_SDRAIN  = 5'd8;
    localparam t_step P_SNEXT   = 5'd9;
    localparam t_step P_CINIT   = 5'd10;
    localparam t_step P_CTEST   = 5'd11;
    localparam t_step P_COLLECT = 5'd12;
    localparam t_step P_CDRAIN  = 5'd13;
    localparam t_step P_RESULT  = 5'd14;
    localparam t_step P_SRET    = 5'd15;
    localparam t_step P_READ    = 5'd16;
    localparam t_step P_RDOUT   = 5'd17;
    localparam t_step P_RRET    = 5'd18;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Status from the datapath that the sequencer tests for jumps.
    typedef struct packed {
        logic no_req;
        logic is_read;
        logic k_lt_top;
        logic sq_gt_top;
        logic not_mark;
        logic kj_le_top;
        logic k_gt_top;
        logic out_busy;
    } t_flags;

    // The control program.
    function automatic t_uword ucode_rom(t_step step);
        t_uword w;
        case (step)
            P_IDLE:    w = '{op: OP_NOP,       cond: C_NO_REQ,    target: P_IDLE};
            P_DISP:    w = '{op: OP_NOP,       cond: C_IS_READ,   target: P_READ};
            P_CLR0:    w = '{op: OP_INIT,      cond: C_NEVER,     target: P_IDLE};
            P_FILL:    w = '{op: OP_FILL,      cond: C_K_LT_TOP,  target: P_FILL};
            P_SINIT:   w = '{op: OP_SINIT,     cond: C_NEVER,     target: P_IDLE};
            P_SCHK:    w = '{op: OP_SQTEST,    cond: C_SQ_GT_TOP, target: P_CINIT};
            P_SJT:     w = '{op: OP_KLOAD,     cond: C_NOT_MARK,  target: P_SNEXT};
            P_STRIKE:  w = '{op: OP_STRIKE,    cond: C_KJ_LE_TOP, target: P_STRIKE};
            P_SDRAIN:  w = '{op: OP_DRAIN_S,   cond: C_NEVER,     target: P_IDLE};
            P_SNEXT:   w = '{op: OP_ADVANCE,   cond: C_ALWAYS,    target: P_SCHK};
            P_CINIT:   w = '{op: OP_CINIT,     cond: C_NEVER,     target: P_IDLE};
            P_CTEST:   w = '{op: OP_NOP,       cond: C_K_GT_TOP,  target: P_RESULT};
            P_COLLECT: w = '{op: OP_COLLECT,   cond: C_K_LT_TOP,  target: P_COLLECT};
            P_CDRAIN:  w = '{op: OP_DRAIN_C,   cond: C_NEVER,     target: P_IDLE};
            P_RESULT:  w = '{op: OP_SWEEP_OUT, cond: C_OUT_BUSY,  target: P_RESULT};
            P_SRET:    w = '{op: OP_NOP,       cond: C_ALWAYS,    target: P_IDLE};
            P_READ:    w = '{op: OP_RD_ISSUE,  cond: C_NEVER,     target: P_IDLE};
            P_RDOUT:   w = '{op: OP_READ_OUT,  cond: C_OUT_BUSY,  target: P_RDOUT};
            P_RRET:    w = '{op: OP_NOP,       cond: C_ALWAYS,    target: P_IDLE};
            default:   w = '{op: OP_NOP,       cond: C_ALWAYS,    target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/pse_useq.sv */
module pse_useq
    import pse_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uword,
    output logic   o_idle
);

    t_step  r_step;
    t_step  n_step;
    t_uword uword;
    logic   take;

    assign uword   = ucode_rom(r_step);
    assign o_uword = uword;
    assign o_idle  = (r_step == P_IDLE);

    always_comb begin
        case (uword.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_REQ:    take = i_flags.no_req;
            C_IS_READ:   take = i_flags.is_read;
            C_K_LT_TOP:  take = i_flags.k_lt_top;
            C_SQ_GT_TOP: take = i_flags.sq_gt_top;
            C_NOT_MARK:  take = i_flags.not_mark;
            C_KJ_LE_TOP: take = i_flags.kj_le_top;
            C_K_GT_TOP:  take = i_flags.k_gt_top;
            C_OUT_BUSY:  take = i_flags.out_busy;
            default:     take = 1'b0;
        endcase
        n_step = take ? uword.target : r_step + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= P_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* sv/pse_dpath.sv */
module pse_dpath
    import pse_pkg::*;
#(
    parameter int MAX_LIMIT = PSE_MAX_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_accept,
    input  t_req        i_req,
    input  t_uword      i_uword,
    input  logic        i_out_stall,
    output t_flags      o_flags,
    output logic        o_out_valid,
    output t_rsp        o_out_data
);

    localparam int AW         = $clog2(MAX_LIMIT + 1);
    localparam int NW         = AW + 1;
    localparam int LW         = $clog2(MAX_LIMIT);
    localparam int MARK_DEPTH = MAX_LIMIT + 1;

    typedef logic [NW-1:0] t_num;

    // Mark bitmap and packed prime list.
    logic          r_mark_mem [0:MARK_DEPTH-1];
    logic [12:0]   r_list_mem [0:MAX_LIMIT-1];

    logic [12:0]   r_limit, n_limit;
    t_num          r_top,   n_top;
    t_num          r_j,     n_j;
    t_num          r_sq,    n_sq;
    t_num          r_k,     n_k;
    t_num          r_pnum,  n_pnum;
    logic [AW-1:0] r_paddr, n_paddr;
    logic          r_pv,    n_pv;
    logic [12:0]   r_cost,  n_cost;
    logic [12:0]   r_found, n_found;
    logic [LW-1:0] r_wp,    n_wp;
    logic          r_cmd,   n_cmd;
    logic [11:0]   r_idx,   n_idx;
    logic          r_inr,   n_inr;
    logic          r_ovalid, n_ovalid;
    t_rsp          r_odata,  n_odata;
    logic          r_mdata;
    logic [12:0]   r_ldata;

    logic          mark_we, mark_wdata, mark_re;
    logic [AW-1:0] mark_waddr, mark_raddr;
    logic          list_we, list_re;
    logic          out_load, out_busy;
    logic [31:0]   lim32, top32, idx32, pnum32;
    t_num          kj;

    assign lim32    = 32'(r_limit);
    assign top32    = (lim32 > 32'(MAX_LIMIT)) ? 32'(MAX_LIMIT) : lim32;
    assign idx32    = 32'(r_idx);
    assign pnum32   = 32'(r_pnum);
    assign kj       = r_k + r_j;
    assign out_busy = r_ovalid && i_out_stall;

    assign o_flags.no_req    = !i_accept;
    assign o_flags.is_read   = (r_cmd == CMD_READ);
    assign o_flags.k_lt_top  = (r_k < r_top);
    assign o_flags.sq_gt_top = (r_sq > r_top);
    assign o_flags.not_mark  = !r_mdata;
    assign o_flags.kj_le_top = (kj <= r_top);
    assign o_flags.k_gt_top  = (r_k > r_top);
    assign o_flags.out_busy  = out_busy;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_comb begin
        n_limit  = r_limit;
        n_top    = r_top;
        n_j      = r_j;
        n_sq     = r_sq;
        n_k      = r_k;
        n_pnum   = r_pnum;
        n_paddr  = r_paddr;
        n_pv     = r_pv;
        n_cost   = r_cost;
        n_found  = r_found;
        n_wp     = r_wp;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_inr    = r_inr;
        n_odata  = r_odata;
        mark_we    = 1'b0;
        mark_wdata = 1'b0;
        mark_waddr = r_paddr;
        mark_re    = 1'b0;
        mark_raddr = r_k[AW-1:0];
        list_we  = 1'b0;
        list_re  = 1'b0;
        out_load = 1'b0;

        case (i_uword.op)
            OP_INIT: begin
                n_top   = top32[NW-1:0];
                n_k     = '0;
                n_cost  = '0;
                n_found = '0;
                n_wp    = '0;
            end
            OP_FILL: begin
                mark_we    = 1'b1;
                mark_wdata = 1'b1;
                mark_waddr = r_k[AW-1:0];
                n_k        = r_k + t_num'(1);
            end
            OP_SINIT: begin
                n_j  = t_num'(2);
                n_sq = t_num'(4);
            end
            OP_SQTEST: begin
                mark_re    = 1'b1;
                mark_raddr = r_j[AW-1:0];
            end
            OP_KLOAD: begin
                n_k  = r_sq;
                n_pv = 1'b0;
            end
            OP_STRIKE: begin
                // Read the next multiple while clearing the one read before.
                mark_re = 1'b1;
                if (r_pv) begin
                    mark_we = 1'b1;
                    if (r_mdata) begin
                        n_cost = r_cost + 13'd1;
                    end
                end
                n_paddr = r_k[AW-1:0];
                n_pv    = 1'b1;
                n_k     = kj;
            end
            OP_DRAIN_S: begin
                if (r_pv) begin
                    mark_we = 1'b1;
                    if (r_mdata) begin
                        n_cost = r_cost + 13'd1;
                    end
                end
                n_pv = 1'b0;
            end
            OP_ADVANCE: begin
                // (j + 1) squared from j squared without a multiplier.
                n_sq = r_sq + {r_j[NW-2:0], 1'b0} + t_num'(1);
                n_j  = r_j + t_num'(1);
            end
            OP_CINIT: begin
                n_k  = t_num'(2);
                n_pv = 1'b0;
            end
            OP_COLLECT: begin
                mark_re = 1'b1;
                n_pnum  = r_k;
                n_pv    = 1'b1;
                n_k     = r_k + t_num'(1);
                if (r_pv && r_mdata) begin
                    list_we = 1'b1;
                    n_wp    = r_wp + LW'(1);
                    n_found = r_found + 13'd1;
                end
            end
            OP_DRAIN_C: begin
                if (r_pv && r_mdata) begin
                    list_we = 1'b1;
                    n_wp    = r_wp + LW'(1);
                    n_found = r_found + 13'd1;
                end
                n_pv = 1'b0;
            end
            OP_SWEEP_OUT: begin
                if (!out_busy) begin
                    out_load             = 1'b1;
                    n_odata.cost         = r_cost;
                    n_odata.prime_count  = r_found;
                    n_odata.prime_value  = '0;
                    n_odata.out_of_range = 1'b0;
                end
            end
            OP_RD_ISSUE: begin
                list_re = 1'b1;
                n_inr   = (idx32 < 32'(r_found)) && (idx32 < 32'(MAX_LIMIT));
            end
            OP_READ_OUT: begin
                if (!out_busy) begin
                    out_load             = 1'b1;
                    n_odata.cost         = r_cost;
                    n_odata.prime_count  = r_found;
                    n_odata.prime_value  = r_inr ? r_ldata : '0;
                    n_odata.out_of_range = !r_inr;
                end
            end
            default: begin
            end
        endcase

        n_ovalid = out_load || out_busy;

        if (i_accept) begin
            n_cmd = i_req.cmd;
            n_idx = i_req.index;
        end
        if (i_cfg_we) begin
            n_limit = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 13'd2;
            r_top    <= '0;
            r_pv     <= 1'b0;
            r_cost   <= '0;
            r_found  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_limit  <= n_limit;
            r_top    <= n_top;
            r_pv     <= n_pv;
            r_cost   <= n_cost;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_sq    <= n_sq;
        r_k     <= n_k;
        r_pnum  <= n_pnum;
        r_paddr <= n_paddr;
        r_wp    <= n_wp;
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_inr   <= n_inr;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_waddr] <= mark_wdata;
        end
        if (mark_re) begin
            r_mdata <= r_mark_mem[mark_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            r_list_mem[r_wp] <= pnum32[12:0];
        end
        if (list_re) begin
            r_ldata <= r_list_mem[idx32[LW-1:0]];
        end
    end

`ifndef ASSERT_OFF
    a_mark_ports_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mark_we && mark_re) |-> (mark_waddr != mark_raddr))
        else $error("mark bitmap read and write hit the same address");

    a_strike_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_STRIKE && r_pv) |-> (r_k == t_num'(r_paddr) + r_j))
        else $error("pending strike is not one stride behind the read");

    a_list_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        list_we |-> (r_pnum >= t_num'(2) && r_pnum <= r_top))
        else $error("prime list written with a number outside the sweep");

    a_one_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> !out_load)
        else $error("response register loaded twice for one request");
`endif

endmodule

/* sv/prime_sieve_engine_unit.sv */
// Sieve of Eratosthenes engine over 0..limit, with limit taken from the
// configuration register (values above MAX_LIMIT are treated as MAX_LIMIT).
// A sweep request refills the mark bitmap, strikes the multiples of every
// prime j with j*j <= limit, counts the strikes that cleared a set mark as
// the cost, and packs the primes in ascending order into the prime list.
// A read request returns the prime at the given index, or zero with the
// out_of_range flag when the index is at or beyond the prime count. Every
// request returns one response carrying the cost and prime count of the last
// sweep. Requests are handled one at a time. A sweep refills the bitmap
// over 0..limit, then for each candidate j tests its mark and, for a prime
// j, strikes one multiple per cycle from j*j on, then packs the list by
// reading the marks of 2..limit in turn. The mark bitmap has a single read
// port, used once per step of the strike and pack loops. A read passes the
// dispatch and list-read steps before its response is loaded, holds while
// the output stalls, and returns to idle through one more step.
// Configuration writes must only be issued while the engine is idle.
module prime_sieve_engine_unit
    import pse_pkg::*;
#(
    parameter int MAX_LIMIT = PSE_MAX_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_data
);

    t_uword uword;
    t_flags flags;
    logic   idle;
    logic   accept;

    // A request is taken only while the program sits in its idle step; the
    // response register lets the next request in while a response waits.
    assign o_in_stall = !idle;
    assign accept     = i_in_valid && idle;

    // Step counter and control program.
    pse_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword),
        .o_idle  (idle)
    );

    // Bitmap, prime list, counters and the response register.
    pse_dpath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_req       (i_in_data),
        .i_uword     (uword),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
